>>> sv/tqla_pkg.sv
package tqla_pkg;

   localparam int NumStatesDef  = 64;
   localparam int ValueWidthDef = 16;
   localparam int NumActions    = 3;
   localparam int RegWidth      = 16;
   localparam int RegIdxWidth   = 3;
   localparam int RewardWidth   = 12;
   localparam int TotalWidth    = 32;
   localparam int DrawWidth     = 14;

   // Register indexes.
   localparam logic [RegIdxWidth-1:0] REG_INIT_EPS  = 3'd0;
   localparam logic [RegIdxWidth-1:0] REG_EPS_FLOOR = 3'd1;
   localparam logic [RegIdxWidth-1:0] REG_EPS_DECAY = 3'd2;
   localparam logic [RegIdxWidth-1:0] REG_DISCOUNT  = 3'd3;
   localparam logic [RegIdxWidth-1:0] REG_LEARN     = 3'd4;

   // Actions.
   localparam logic [1:0] ACT_BACKOFF = 2'd0;
   localparam logic [1:0] ACT_CCA     = 2'd1;
   localparam logic [1:0] ACT_SEND    = 2'd2;

   localparam logic FUNC_SELECT = 1'b0;
   localparam logic FUNC_UPDATE = 1'b1;

   // Rewards in signed Q4.8: twelve bits, eight of them fraction bits.
   localparam logic signed [RewardWidth-1:0] RW_BACKOFF   = 12'sd307;
   localparam logic signed [RewardWidth-1:0] RW_CCA_BUSY  = 12'sd256;
   localparam logic signed [RewardWidth-1:0] RW_CCA_OK    = 12'sd768;
   localparam logic signed [RewardWidth-1:0] RW_CCA_FAIL  = -12'sd512;
   localparam logic signed [RewardWidth-1:0] RW_SEND_OK   = 12'sd1024;
   localparam logic signed [RewardWidth-1:0] RW_SEND_FAIL = -12'sd768;

   localparam int DrawScale = 10000;
   localparam int ValueInit = -2560;
   localparam int ValueStep = 256;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SEL_RD, ST_SEL_EPS, ST_SEL_DONE,
      ST_UPD_RD, ST_UPD_MAX, ST_UPD_DISC, ST_UPD_LR, ST_UPD_WR, ST_UPD_POL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [RegWidth-1:0] initial_epsilon;
      logic [RegWidth-1:0] epsilon_floor;
      logic [RegWidth-1:0] epsilon_decay;
      logic [RegWidth-1:0] discount;
      logic [RegWidth-1:0] learn_rate;
   } csr_type;

   function automatic logic signed [RewardWidth-1:0] reward_of(
      input logic [1:0] act, input logic clear, input logic ok);
      logic signed [RewardWidth-1:0] r;
      case (act)
         ACT_BACKOFF: r = RW_BACKOFF;
         ACT_CCA:     r = !clear ? RW_CCA_BUSY : (ok ? RW_CCA_OK : RW_CCA_FAIL);
         default:     r = ok ? RW_SEND_OK : RW_SEND_FAIL;
      endcase
      return r;
   endfunction

endpackage

>>> sv/tqla_if.sv
interface tqla_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [5:0]  state_id;
   logic        explore_off;
   logic [13:0] random_draw;
   logic [1:0]  random_action;
   logic        channel_clear;
   logic        tx_success;
   modport source (output valid, func, state_id, explore_off, random_draw,
                   random_action, channel_clear, tx_success, input ready);
   modport sink   (input valid, func, state_id, explore_off, random_draw,
                   random_action, channel_clear, tx_success, output ready);
endinterface

interface tqla_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic               was_random;
   logic [15:0]        epsilon_now;
   logic [1:0]         policy_action;
   logic signed [11:0] reward_value;
   logic signed [31:0] reward_total;
   modport source (output valid, action, was_random, epsilon_now, policy_action,
                   reward_value, reward_total, input ready);
   modport sink   (input valid, action, was_random, epsilon_now, policy_action,
                   reward_value, reward_total, output ready);
endinterface

>>> sv/tqla_value_mem.sv
// Value table: one row per state holding all three action values.
module tqla_value_mem import tqla_pkg::*; #(
   parameter int NUM_STATES  = NumStatesDef,
   parameter int VALUE_WIDTH = ValueWidthDef,
   localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [SW-1:0]                         wr_addr,
   input  logic [NumActions*VALUE_WIDTH+1:0]     wr_data,
   input  logic [SW-1:0]                         rd_addr,
   output logic [NumActions*VALUE_WIDTH+1:0]     rd_data
);
   logic [NumActions*VALUE_WIDTH+1:0] mem [NUM_STATES];

   // Synchronous write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/tqla_mult.sv
// Registered signed multiply of a value by an unsigned Q0.16 rate, floor / 65536.
module tqla_mult import tqla_pkg::*; #(
   parameter int AW = 18
) (
   input  logic                 clock,
   input  logic signed [AW-1:0] a,
   input  logic [RegWidth-1:0]  rate,
   output logic signed [AW-1:0] p
);
   logic signed [AW+RegWidth:0] prod;
   logic signed [AW-1:0]        p_in;

   always_comb begin
      prod = a * $signed({1'b0, rate});
      // Arithmetic shift is floor division by 65536.
      p_in = AW'(prod >>> RegWidth);
   end

   always_ff @(posedge clock) begin
      p <= p_in;
   end
endmodule

>>> sv/tabular_q_learning_agent_unit.sv
// A select passes through the read, epsilon and done states before its result is registered; an update
// passes through the read, max, discount, learning-rate, write and policy states. One word at a time: the
// next word is taken the cycle after the result is taken. The value table read, the shared multiplier
// (used twice per update) and the write-back set this state sequence.
// Reset is synchronous; afterward a clearing pass writes the reset row to every
// value table entry, during which no word is accepted.
module tabular_q_learning_agent_unit import tqla_pkg::*; #(
   parameter int NUM_STATES  = NumStatesDef,
   parameter int VALUE_WIDTH = ValueWidthDef
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [RegIdxWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]    csr_data,
   tqla_req_if.sink               req,
   tqla_rsp_if.source             rsp
);
   localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int VW = VALUE_WIDTH;
   localparam int AW = (VW + 3 > RegWidth + 2) ? VW + 3 : RegWidth + 2;
   localparam int RW = NumActions * VW + 2;
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
   // The reset value saturates to the value width.
   localparam logic signed [VW-1:0] VINIT =
      (longint'(ValueInit) < -(longint'(1) <<< (VW - 1))) ? VMIN : VW'(ValueInit);

   state_type state_ff, state_in;
   csr_type   csr_ff;
   logic [RegWidth-1:0]   eps_ff, eps_in;
   logic [SW-1:0]         last_state_ff, last_state_in;
   logic [1:0]            last_action_ff, last_action_in;
   logic signed [TotalWidth-1:0] sum_ff, sum_in;
   logic [SW:0]           clr_ff, clr_in;

   // Held request word.
   logic              func_ff, xoff_ff, clear_ff, ok_ff;
   logic [SW-1:0]     sid_ff;
   logic [DrawWidth-1:0] draw_ff;
   logic [1:0]        ract_ff;

   // Result word.
   logic              rvalid_ff, rvalid_in;
   logic [1:0]        ract_out_ff, ract_out_in;
   logic              rnd_ff, rnd_in;
   logic [1:0]        pol_ff, pol_in;
   logic signed [RewardWidth-1:0] rew_ff, rew_in;

   // Datapath registers.
   logic signed [VW-1:0] q_ff, q_in, max_ff, max_in;
   logic [RW-1:0]        row_ff, row_in;
   logic signed [AW-1:0] tgt_ff, tgt_in;

   // Memory signals.
   logic          wr_en;
   logic [SW-1:0] wr_addr, rd_addr;
   logic [RW-1:0] wr_data, rd_data;

   tqla_value_mem #(.NUM_STATES(NUM_STATES), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data);

   // Shared multiplier: epsilon decay, discount, then learning rate.
   logic signed [AW-1:0] mul_a, mul_p;
   logic [RegWidth-1:0]  mul_rate;
   tqla_mult #(.AW(AW)) u_mult (.clock, .a(mul_a), .rate(mul_rate), .p(mul_p));

   logic [RegWidth-1:0] eps_p;
   logic [RegWidth+1:0] eps_mul_a;
   logic [47:0] lhs, rhs;
   logic signed [VW-1:0] v0, v1, v2, qsel, qnew;
   logic [1:0] pol_row, best;
   logic signed [AW-1:0] delta, qsum;

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.action = ract_out_ff;
   assign rsp.was_random = rnd_ff;
   assign rsp.epsilon_now = eps_ff;
   assign rsp.policy_action = pol_ff;
   assign rsp.reward_value = rew_ff;
   assign rsp.reward_total = sum_ff;

   // Epsilon widened as a non-negative operand of the shared multiplier.
   assign eps_mul_a = {2'b00, eps_ff};

   always_comb begin
      v0 = row_ff[VW-1:0];
      v1 = row_ff[2*VW-1:VW];
      v2 = row_ff[3*VW-1:2*VW];
      pol_row = row_ff[RW-1:RW-2];
      case (last_action_ff)
         ACT_BACKOFF: qsel = v0;
         ACT_CCA:     qsel = v1;
         default:     qsel = v2;
      endcase
      delta = mul_p;
      qsum = AW'(q_ff) + delta;
      if (delta > 0) begin
         if (qsum > AW'(VMAX)) qnew = VMAX;
         else qnew = VW'(qsum);
      end else begin
         if (AW'(q_ff) - AW'(ValueStep) < AW'(VMIN)) qnew = VMIN;
         else qnew = VW'(AW'(q_ff) - AW'(ValueStep));
      end
      eps_p = mul_p[RegWidth-1:0];
      lhs = {18'd0, draw_ff, 16'd0};
      rhs = 48'(eps_in) * 48'(DrawScale);
   end

   // Arg-max with ties to the higher index over the updated row.
   function automatic logic [1:0] argmax3(input logic signed [VW-1:0] a0,
      input logic signed [VW-1:0] a1, input logic signed [VW-1:0] a2);
      logic signed [VW-1:0] m;
      logic [1:0] b;
      m = a0; b = ACT_BACKOFF;
      if (a1 >= m) begin m = a1; b = ACT_CCA; end
      if (a2 >= m) begin b = ACT_SEND; end
      return b;
   endfunction

   // Fold a state id into the table range through a constant lookup over all ids.
   function automatic logic [SW-1:0] fold_state(input logic [5:0] s);
      logic [SW-1:0] r;
      r = '0;
      for (int i = 0; i < 64; i++) begin
         if (s == 6'(i)) r = SW'(i % NUM_STATES);
      end
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      eps_in = eps_ff;
      last_state_in = last_state_ff;
      last_action_in = last_action_ff;
      sum_in = sum_ff;
      clr_in = clr_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      ract_out_in = ract_out_ff;
      rnd_in = rnd_ff;
      pol_in = pol_ff;
      rew_in = rew_ff;
      q_in = q_ff;
      max_in = max_ff;
      row_in = row_ff;
      tgt_in = tgt_ff;
      wr_en = 1'b0;
      wr_addr = last_state_ff;
      wr_data = row_ff;
      rd_addr = sid_ff;
      mul_a = '0;
      mul_rate = '0;
      best = argmax3(v0, v1, v2);
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[SW-1:0];
            wr_data = {ACT_BACKOFF, VINIT, VINIT, VINIT};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SW+1)'(NUM_STATES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               state_in = (req.func == FUNC_SELECT) ? ST_SEL_RD : ST_UPD_RD;
            end
         end
         ST_SEL_RD: begin
            // Memory read of the selected row in flight; start epsilon decay.
            mul_a = $signed(AW'(eps_mul_a));
            mul_rate = csr_ff.epsilon_decay;
            state_in = ST_SEL_EPS;
         end
         ST_SEL_EPS: begin
            row_in = rd_data;
            eps_in = (eps_p > csr_ff.epsilon_floor) ? eps_p : csr_ff.epsilon_floor;
            last_state_in = sid_ff;
            pol_in = rd_data[RW-1:RW-2];
            rnd_in = 1'b0;
            if (!xoff_ff && (lhs < rhs)) begin
               last_action_in = (ract_ff > ACT_SEND) ? ACT_SEND : ract_ff;
               rnd_in = 1'b1;
            end else begin
               last_action_in = rd_data[RW-1:RW-2];
            end
            state_in = ST_SEL_DONE;
         end
         ST_SEL_DONE: begin
            ract_out_in = last_action_ff;
            rew_in = '0;
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_UPD_RD: begin
            // Next-state row requested.
            rd_addr = sid_ff;
            state_in = ST_UPD_MAX;
         end
         ST_UPD_MAX: begin
            row_in = rd_data;
            rd_addr = last_state_ff;
            state_in = ST_UPD_DISC;
         end
         ST_UPD_DISC: begin
            // Best value of the next state times discount; own row arrives.
            max_in = (v1 > v0) ? v1 : v0;
            if (v2 > ((v1 > v0) ? v1 : v0)) max_in = v2;
            mul_a = AW'((v2 > ((v1 > v0) ? v1 : v0)) ? v2 : ((v1 > v0) ? v1 : v0));
            mul_rate = csr_ff.discount;
            row_in = rd_data;
            rew_in = reward_of(last_action_ff, clear_ff, ok_ff);
            state_in = ST_UPD_LR;
         end
         ST_UPD_LR: begin
            q_in = qsel;
            tgt_in = AW'(rew_ff) + mul_p - AW'(qsel);
            mul_a = AW'(rew_ff) + mul_p - AW'(qsel);
            mul_rate = csr_ff.learn_rate;
            if (TotalWidth'(sum_ff + TotalWidth'(rew_ff)) < 0 && sum_ff >= 0
                && rew_ff > 0) begin
               sum_in = {1'b0, {(TotalWidth-1){1'b1}}};
            end else if (TotalWidth'(sum_ff + TotalWidth'(rew_ff)) >= 0 && sum_ff < 0
                && rew_ff < 0) begin
               sum_in = {1'b1, {(TotalWidth-1){1'b0}}};
            end else begin
               sum_in = sum_ff + TotalWidth'(rew_ff);
            end
            state_in = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            case (last_action_ff)
               ACT_BACKOFF: row_in[VW-1:0] = qnew;
               ACT_CCA:     row_in[2*VW-1:VW] = qnew;
               default:     row_in[3*VW-1:2*VW] = qnew;
            endcase
            q_in = (delta > 0) ? q_ff : '0;
            max_in = (delta > 0) ? VMAX : '0;
            state_in = ST_UPD_POL;
         end
         ST_UPD_POL: begin
            // Policy follows the arg-max only when the value rose.
            wr_en = 1'b1;
            wr_addr = last_state_ff;
            wr_data = {(max_ff == VMAX && tgt_ff != '0) ? best : pol_row,
                       row_ff[3*VW-1:0]};
            if (max_ff == VMAX) wr_data[RW-1:RW-2] = best;
            else wr_data[RW-1:RW-2] = pol_row;
            pol_in = wr_data[RW-1:RW-2];
            ract_out_in = last_action_ff;
            rnd_in = 1'b0;
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // A write of the starting rate also loads the current rate.
      if (csr_wr_en && csr_index == REG_INIT_EPS) eps_in = csr_data;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rvalid_ff <= 1'b0;
         eps_ff <= 16'hFFFF;
         last_state_ff <= '0;
         last_action_ff <= ACT_BACKOFF;
         sum_ff <= '0;
         csr_ff <= '{16'd65535, 16'd655, 16'd65470, 16'd58982, 16'd6554};
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rvalid_ff <= rvalid_in;
         eps_ff <= eps_in;
         last_state_ff <= last_state_in;
         last_action_ff <= last_action_in;
         sum_ff <= sum_in;
         if (csr_wr_en) begin
            case (csr_index)
               REG_INIT_EPS:  csr_ff.initial_epsilon <= csr_data;
               REG_EPS_FLOOR: csr_ff.epsilon_floor <= csr_data;
               REG_EPS_DECAY: csr_ff.epsilon_decay <= csr_data;
               REG_DISCOUNT:  csr_ff.discount <= csr_data;
               REG_LEARN:     csr_ff.learn_rate <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         func_ff <= req.func;
         sid_ff <= fold_state(req.state_id);
         xoff_ff <= req.explore_off;
         draw_ff <= req.random_draw;
         ract_ff <= req.random_action;
         clear_ff <= req.channel_clear;
         ok_ff <= req.tx_success;
      end
      ract_out_ff <= ract_out_in;
      rnd_ff <= rnd_in;
      pol_ff <= pol_in;
      rew_ff <= rew_in;
      q_ff <= q_in;
      max_ff <= max_in;
      row_ff <= row_in;
      tgt_ff <= tgt_in;
   end

   logic unused_ok;
   assign unused_ok = func_ff ^ csr_ff.initial_epsilon[0];
endmodule

>>> sv/tqla_checker.sv
// Port-level checks on the agent.
module tqla_checker import tqla_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_action,
   input logic [1:0]         rsp_policy_action,
   input logic               rsp_was_random,
   input logic signed [11:0] rsp_reward_value
);
   // A result word holds while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action))
      else $error("result word dropped while stalled");

   // Actions never take the unused code.
   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action != 2'd3 && rsp_policy_action != 2'd3)
      else $error("action out of range");

   // An exploring select carries no reward.
   a_rand_reward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_random |-> rsp_reward_value == '0)
      else $error("random select with reward");

   // No new word is taken while a result waits.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("word accepted while result pending");
endmodule

bind tabular_q_learning_agent_unit tqla_checker u_tqla_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_action(rsp.action), .rsp_policy_action(rsp.policy_action),
   .rsp_was_random(rsp.was_random), .rsp_reward_value(rsp.reward_value));
